/* rtl/gtpv2_header_ie_parser_macros.svh */
// Assertion macros for the GTPv2 header and IE parser core.
`ifndef GTPV2_HEADER_IE_PARSER_MACROS_SVH
`define GTPV2_HEADER_IE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define GTPH_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtph assertion failed");
`define GTPH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtph assertion failed");
`else
`define GTPH_ASSERT_SAME(name, ante, cons)
`define GTPH_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* rtl/gtph_pkg.sv */
// Types and constants for the GTPv2 header and IE parser.
package gtph_pkg;

  localparam int MAX_DIGITS_DEF = 15;
  localparam int LEN_BITS_DEF   = 16;

  localparam int DIGITS_W = 60;
  localparam int COUNT_W  = 4;
  localparam int HDR_BYTES = 12;

  localparam logic [7:0] VER_MASK = 8'hE8;
  localparam logic [7:0] VER_VAL  = 8'h48;
  localparam logic [3:0] FILLER   = 4'hF;

  localparam logic [7:0] IE_IMSI   = 8'd1;
  localparam logic [7:0] IE_CAUSE  = 8'd2;
  localparam logic [7:0] IE_MSISDN = 8'd76;
  localparam logic [7:0] IE_FTEID  = 8'd87;

  localparam logic [7:0] MSG_CREATE_SESS_REQ = 8'd32;
  localparam logic [7:0] MSG_DELETE_SESS_REQ = 8'd36;

  typedef enum logic [1:0] {
    ST_PARSED  = 2'd0,
    ST_BAD_VER = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [7:0]            msg_type;
    logic [31:0]           tunnel_id;
    logic [31:0]           sequence_word;
    logic [7:0]            cause_value;
    logic [DIGITS_W-1:0]   imsi_digits;
    logic [COUNT_W-1:0]    imsi_count;
    logic [DIGITS_W-1:0]   msisdn_digits;
    logic [COUNT_W-1:0]    msisdn_count;
    logic                  truncated;
  } result_t;

endpackage

/* rtl/gtph_in_if.sv */
// Byte input channel: valid/ready plus one payload byte and its last mark.
interface gtph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, payload_byte, last_byte, input ready);
  modport sink   (input valid, payload_byte, last_byte, output ready);
endinterface

/* rtl/gtph_out_if.sv */
// Result channel: valid/ready plus the parsed header and IE fields.
interface gtph_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [7:0]                      msg_type;
  logic [31:0]                     tunnel_id;
  logic [31:0]                     sequence_word;
  logic [7:0]                      cause_value;
  logic [gtph_pkg::DIGITS_W-1:0]   imsi_digits;
  logic [gtph_pkg::COUNT_W-1:0]    imsi_count;
  logic [gtph_pkg::DIGITS_W-1:0]   msisdn_digits;
  logic [gtph_pkg::COUNT_W-1:0]    msisdn_count;
  logic                            truncated;

  modport source (output valid, status, msg_type, tunnel_id, sequence_word, cause_value,
                  imsi_digits, imsi_count, msisdn_digits, msisdn_count, truncated,
                  input ready);
  modport sink   (input valid, status, msg_type, tunnel_id, sequence_word, cause_value,
                  imsi_digits, imsi_count, msisdn_digits, msisdn_count, truncated,
                  output ready);
endinterface

/* rtl/gtph_in_stage.sv */
// Input register: holds one accepted byte until the parser core takes it.
module gtph_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  gtph_in_if.sink            in_ch,
  input  logic               take,
  output gtph_pkg::in_item_t item
);

  logic       vld_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       rdy;

  assign rdy         = !vld_r || take;
  assign in_ch.ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && rdy) begin
      data_r <= in_ch.payload_byte;
      last_r <= in_ch.last_byte;
    end
  end

  assign item.vld  = vld_r;
  assign item.data = data_r;
  assign item.last = last_r;

endmodule

/* rtl/gtph_core.sv */
// Parser core: header and IE state, updated once per byte, plus result build.
`include "gtpv2_header_ie_parser_macros.svh"
module gtph_core #(
  parameter int MAX_DIGITS = gtph_pkg::MAX_DIGITS_DEF,
  parameter int LEN_BITS   = gtph_pkg::LEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gtph_pkg::in_item_t  s_in,
  input  logic                out_can,
  output logic                take,
  output logic                res_vld,
  output gtph_pkg::result_t   res
);

  localparam int LB = LEN_BITS;
  localparam int DW = 4 * MAX_DIGITS;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  // IE walk offset: idle, three header bytes, then content (saturating)
  localparam logic [3:0] OFF_IDLE    = 4'd0;
  localparam logic [3:0] OFF_LEN_HI  = 4'd1;
  localparam logic [3:0] OFF_LEN_LO  = 4'd2;
  localparam logic [3:0] OFF_FLAGS   = 4'd3;
  localparam logic [3:0] OFF_CONTENT = 4'd4;
  localparam logic [3:0] OFF_CAUSE_OK = 4'd5;
  localparam logic [3:0] OFF_FTEID_LO = 4'd5;
  localparam logic [3:0] OFF_FTEID_HI = 4'd8;
  localparam logic [3:0] OFF_FTEID_OK = 4'd9;
  localparam logic [3:0] OFF_SAT      = 4'd15;

  logic [LB-1:0] pos_r, pos_nxt;
  logic          hdr_ok_r, hdr_ok_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [LB-1:0] hlen_r, hlen_nxt;
  logic [31:0]   teid_r, teid_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [7:0]    kind_r, kind_nxt;
  logic [LB-1:0] ilen_r, ilen_nxt;
  logic [3:0]    ioff_r, ioff_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [7:0]    cause_r, cause_nxt;
  logic [DW-1:0] imsi_r, imsi_nxt;
  logic [DW-1:0] msisdn_r, msisdn_nxt;
  logic [3:0]    imsi_cnt_r, imsi_cnt_nxt;
  logic [3:0]    msisdn_cnt_r, msisdn_cnt_nxt;
  logic          stop_r, stop_nxt;
  logic [DW-1:0] scr_r, scr_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt;

  logic [7:0]    b;
  logic          create, del;
  logic [LB-1:0] region, rel, ilen_dec;
  logic          commit;
  logic [3:0]    cm_off;
  logic [3:0]    lo, hi;
  logic          lo_ok, hi_ok, dig_en;
  logic [CW-1:0] n1;
  logic          clear;

  assign b      = s_in.data;
  assign take   = s_in.vld && (!s_in.last || out_can);
  assign clear  = take && s_in.last;
  assign create = (type_r == gtph_pkg::MSG_CREATE_SESS_REQ);
  assign del    = (type_r == gtph_pkg::MSG_DELETE_SESS_REQ);
  assign region = (hlen_r >= LB'(8)) ? hlen_r - LB'(8) : '0;
  assign rel    = pos_r - LB'(gtph_pkg::HDR_BYTES);
  assign ilen_dec = ilen_r - LB'(1);

  // BCD unpack: low nibble always a digit, high nibble a digit unless filler
  assign lo     = b[3:0];
  assign hi     = b[7:4];
  assign dig_en = create && !stop_r &&
                  (kind_r == gtph_pkg::IE_IMSI || kind_r == gtph_pkg::IE_MSISDN);
  assign lo_ok  = scnt_r < CW'(MAX_DIGITS);
  assign n1     = scnt_r + CW'(lo_ok);
  assign hi_ok  = (hi != gtph_pkg::FILLER) && (n1 < CW'(MAX_DIGITS));

  always_comb begin
    pos_nxt        = pos_r;
    hdr_ok_nxt     = hdr_ok_r;
    type_nxt       = type_r;
    hlen_nxt       = hlen_r;
    teid_nxt       = teid_r;
    seq_nxt        = seq_r;
    kind_nxt       = kind_r;
    ilen_nxt       = ilen_r;
    ioff_nxt       = ioff_r;
    acc_nxt        = acc_r;
    cause_nxt      = cause_r;
    imsi_nxt       = imsi_r;
    msisdn_nxt     = msisdn_r;
    imsi_cnt_nxt   = imsi_cnt_r;
    msisdn_cnt_nxt = msisdn_cnt_r;
    stop_nxt       = stop_r;
    scr_nxt        = scr_r;
    scnt_nxt       = scnt_r;
    commit         = 1'b0;
    cm_off         = ioff_r;

    if (!(&pos_r)) begin
      pos_nxt = pos_r + LB'(1);
      priority if (pos_r == LB'(0)) begin
        hdr_ok_nxt = ((b & gtph_pkg::VER_MASK) == gtph_pkg::VER_VAL);
      end else if (pos_r == LB'(1)) begin
        type_nxt = b;
      end else if (pos_r == LB'(2)) begin
        hlen_nxt = LB'({b, 8'h00});
      end else if (pos_r == LB'(3)) begin
        hlen_nxt = hlen_r | LB'(b);
      end else if (pos_r < LB'(8)) begin
        teid_nxt = {teid_r[23:0], b};
      end else if (pos_r < LB'(gtph_pkg::HDR_BYTES)) begin
        seq_nxt = {seq_r[23:0], b};
      end else begin
        unique case (ioff_r)
          OFF_IDLE: begin
            if (hdr_ok_r && rel < region) begin
              kind_nxt = b;
              ilen_nxt = '0;
              acc_nxt  = '0;
              scr_nxt  = '0;
              scnt_nxt = '0;
              stop_nxt = 1'b0;
              ioff_nxt = OFF_LEN_HI;
            end
          end
          OFF_LEN_HI: begin
            ilen_nxt = LB'({b, 8'h00});
            ioff_nxt = OFF_LEN_LO;
          end
          OFF_LEN_LO: begin
            ilen_nxt = ilen_r | LB'(b);
            ioff_nxt = OFF_FLAGS;
          end
          OFF_FLAGS: begin
            ioff_nxt = OFF_CONTENT;
            cm_off   = OFF_CONTENT;
            if (ilen_r == '0) begin
              commit   = 1'b1;
              ioff_nxt = OFF_IDLE;
            end
          end
          default: begin
            if (kind_r == gtph_pkg::IE_CAUSE && ioff_r == OFF_CONTENT) begin
              acc_nxt = {24'h0, b};
            end
            if (kind_r == gtph_pkg::IE_FTEID &&
                ioff_r >= OFF_FTEID_LO && ioff_r <= OFF_FTEID_HI) begin
              acc_nxt = {acc_r[23:0], b};
            end
            if (dig_en) begin
              for (int i = 0; i < MAX_DIGITS; i++) begin
                if (lo_ok && scnt_r == CW'(i)) begin
                  scr_nxt[4*i +: 4] = lo;
                end
                if (hi_ok && n1 == CW'(i)) begin
                  scr_nxt[4*i +: 4] = hi;
                end
              end
              scnt_nxt = n1 + CW'(hi_ok);
              stop_nxt = (hi == gtph_pkg::FILLER);
            end
            ioff_nxt = (ioff_r == OFF_SAT) ? OFF_SAT : ioff_r + 4'd1;
            cm_off   = ioff_nxt;
            ilen_nxt = ilen_dec;
            if (ilen_dec == '0) begin
              commit   = 1'b1;
              ioff_nxt = OFF_IDLE;
            end
          end
        endcase
      end
    end

    // a zero-length IE whose header ends on the final byte is dropped
    if (commit && !(cm_off == OFF_CONTENT && s_in.last)) begin
      if (kind_r == gtph_pkg::IE_FTEID && (create || del) && cm_off >= OFF_FTEID_OK) begin
        teid_nxt = acc_nxt;
      end
      if (kind_r == gtph_pkg::IE_CAUSE && cm_off >= OFF_CAUSE_OK) begin
        cause_nxt = acc_nxt[7:0];
      end
      if (create && kind_r == gtph_pkg::IE_IMSI) begin
        imsi_nxt     = scr_nxt;
        imsi_cnt_nxt = 4'(scnt_nxt);
      end
      if (create && kind_r == gtph_pkg::IE_MSISDN) begin
        msisdn_nxt     = scr_nxt;
        msisdn_cnt_nxt = 4'(scnt_nxt);
      end
    end
  end

  // result from the state as it stands after the final byte
  always_comb begin
    res     = '0;
    res_vld = clear;
    if (!hdr_ok_nxt) begin
      res.status = gtph_pkg::ST_BAD_VER;
    end else if (pos_nxt < LB'(gtph_pkg::HDR_BYTES)) begin
      res.status = gtph_pkg::ST_SHORT;
    end else begin
      res.status        = gtph_pkg::ST_PARSED;
      res.msg_type      = type_nxt;
      res.tunnel_id     = teid_nxt;
      res.sequence_word = seq_nxt;
      res.cause_value   = cause_nxt;
      res.imsi_digits   = gtph_pkg::DIGITS_W'(imsi_nxt);
      res.imsi_count    = imsi_cnt_nxt;
      res.msisdn_digits = gtph_pkg::DIGITS_W'(msisdn_nxt);
      res.msisdn_count  = msisdn_cnt_nxt;
      res.truncated     = ({1'b0, hlen_nxt} + (LB+1)'(4)) > {1'b0, pos_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pos_r        <= '0;
      hdr_ok_r     <= 1'b0;
      type_r       <= '0;
      hlen_r       <= '0;
      teid_r       <= '0;
      seq_r        <= '0;
      kind_r       <= '0;
      ilen_r       <= '0;
      ioff_r       <= OFF_IDLE;
      acc_r        <= '0;
      cause_r      <= '0;
      imsi_r       <= '0;
      msisdn_r     <= '0;
      imsi_cnt_r   <= '0;
      msisdn_cnt_r <= '0;
      stop_r       <= 1'b0;
      scr_r        <= '0;
      scnt_r       <= '0;
    end else if (take) begin
      pos_r        <= pos_nxt;
      hdr_ok_r     <= hdr_ok_nxt;
      type_r       <= type_nxt;
      hlen_r       <= hlen_nxt;
      teid_r       <= teid_nxt;
      seq_r        <= seq_nxt;
      kind_r       <= kind_nxt;
      ilen_r       <= ilen_nxt;
      ioff_r       <= ioff_nxt;
      acc_r        <= acc_nxt;
      cause_r      <= cause_nxt;
      imsi_r       <= imsi_nxt;
      msisdn_r     <= msisdn_nxt;
      imsi_cnt_r   <= imsi_cnt_nxt;
      msisdn_cnt_r <= msisdn_cnt_nxt;
      stop_r       <= stop_nxt;
      scr_r        <= scr_nxt;
      scnt_r       <= scnt_nxt;
    end
  end

  `GTPH_ASSERT_NEXT(a_clear_after_last, take && s_in.last, pos_r == '0 && ioff_r == OFF_IDLE)
  `GTPH_ASSERT_SAME(a_ie_walk_needs_hdr, ioff_r != OFF_IDLE, hdr_ok_r)
  `GTPH_ASSERT_SAME(a_digit_count_bound, 1'b1, scnt_r <= CW'(MAX_DIGITS))
  `GTPH_ASSERT_SAME(a_bad_ver_no_fields, res_vld && res.status == gtph_pkg::ST_BAD_VER, res.tunnel_id == '0 && res.truncated == 1'b0)

endmodule

/* rtl/gtph_out_stage.sv */
// Result register: holds one finished result until the receiver takes it.
module gtph_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  gtph_pkg::result_t res,
  output logic              out_can,
  gtph_out_if.source        out_ch
);

  logic              vld_r;
  gtph_pkg::result_t data_r;

  assign out_can = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_vld) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      data_r <= res;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.status        = data_r.status;
  assign out_ch.msg_type      = data_r.msg_type;
  assign out_ch.tunnel_id     = data_r.tunnel_id;
  assign out_ch.sequence_word = data_r.sequence_word;
  assign out_ch.cause_value   = data_r.cause_value;
  assign out_ch.imsi_digits   = data_r.imsi_digits;
  assign out_ch.imsi_count    = data_r.imsi_count;
  assign out_ch.msisdn_digits = data_r.msisdn_digits;
  assign out_ch.msisdn_count  = data_r.msisdn_count;
  assign out_ch.truncated     = data_r.truncated;

endmodule

/* rtl/gtpv2_header_ie_parser.sv */
// Top level of the GTPv2-C header and IE parser.
// Usage:
//   in_ch carries the UDP payload of one GTPv2-C message, one byte per
//   transaction, with last_byte set on the final byte. Bytes of the next
//   message may follow right behind the final one.
//   out_ch carries one result transaction per message, issued for its
//   final byte: status, message type, TEID (the F-TEID TEID in create or
//   delete session requests), sequence word, cause, IMSI and MSISDN digits
//   with their counts, and a truncation flag.
// Timing:
//   One byte per cycle sustained while no final byte waits on a full result
//   register. A byte lands in the input register, and the parser core
//   updates its registers when it takes the byte; for a final byte the
//   result register loads at that same edge and holds the result until taken.
// Backpressure:
//   While the result register is full and not taken, only a final byte
//   waits in the input register; other bytes keep flowing, so a stalled
//   receiver costs nothing until the next message ends.
// Reset:
//   rst_n (synchronous) empties both registers and clears all parser
//   state; the parser also returns to that state after every final byte.
module gtpv2_header_ie_parser #(
  parameter int MAX_DIGITS = gtph_pkg::MAX_DIGITS_DEF,
  parameter int LEN_BITS   = gtph_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gtph_in_if.sink     in_ch,
  gtph_out_if.source  out_ch
);

  gtph_pkg::in_item_t item;
  gtph_pkg::result_t  res;
  logic               take;
  logic               res_vld;
  logic               out_can;

  // input transaction register
  gtph_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  // per-byte header/IE state and result assembly
  gtph_core #(
    .MAX_DIGITS (MAX_DIGITS),
    .LEN_BITS   (LEN_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_in    (item),
    .out_can (out_can),
    .take    (take),
    .res_vld (res_vld),
    .res     (res)
  );

  // result transaction register
  gtph_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_vld (res_vld),
    .res     (res),
    .out_can (out_can),
    .out_ch  (out_ch)
  );

endmodule
